### src/cvm_pkg.sv
// Shared types, constants and helper functions for the camera view matrix block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package cvm_pkg;

   // Datapath widths
   localparam int MUL_W  = 34;
   localparam int PROD_W = 68;
   localparam int ACC_W  = 50;
   localparam int WRAP_W = 20;

   // Operation codes
   localparam logic [1:0] FUNC_UPDATE = 2'd0;
   localparam logic [1:0] FUNC_MOVE   = 2'd1;
   localparam logic [1:0] FUNC_ROTATE = 2'd2;

   // Move directions
   localparam logic [2:0] DIR_FORWARD      = 3'd0;
   localparam logic [2:0] DIR_BACKWARD     = 3'd1;
   localparam logic [2:0] DIR_RIGHT        = 3'd2;
   localparam logic [2:0] DIR_LEFT         = 3'd3;
   localparam logic [2:0] DIR_STRAFE_RIGHT = 3'd4;
   localparam logic [2:0] DIR_STRAFE_LEFT  = 3'd5;

   // Register indexes and reset values
   localparam logic CSR_SPEED = 1'b0;
   localparam logic CSR_SENS  = 1'b1;
   localparam logic [15:0] SPEED_RESET = 16'd640;
   localparam logic [15:0] SENS_RESET  = 16'd6554;

   // Angle constants, Q9.7 degrees
   localparam int PITCH_LIMIT  = 11392;
   localparam int FULL_TURN    = 46080;
   localparam int QUARTER_TURN = 11520;

   localparam logic [17:0] RAD_PER_UNIT = 18'd146409;
   localparam logic [13:0] INV_SQRT2    = 14'd11585;
   localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [16:0] SINE_CAP = 17'd16384;

   localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] S32_MIN = PROD_W'(-64'sd2147483648);

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         move_dir;
      logic [15:0]        delta_time;
      logic signed [15:0] mouse_dx;
      logic signed [15:0] mouse_dy;
   } req_type;

   typedef struct packed {
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic signed [31:0] shift_z;
   } rsp_type;

   typedef struct packed {
      logic [15:0] speed;
      logic [15:0] sens;
   } cfg_type;

   typedef struct packed {
      logic    start;
      req_type item;
   } core_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

   // Reciprocal, shift and divisor for the Taylor divide steps 72, 42, 20, 6
   function automatic logic [31:0] div_recip(input logic [1:0] k);
      logic [31:0] r;
      case (k)
         2'd0:    r = 32'd3817748707;
         2'd1:    r = 32'd3272355082;
         2'd2:    r = 32'd3435973836;
         default: r = 32'd2863311530;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] div_shift(input logic [1:0] k);
      logic [5:0] s;
      case (k)
         2'd0:    s = 6'd38;
         2'd1:    s = 6'd37;
         2'd2:    s = 6'd36;
         default: s = 6'd34;
      endcase
      return s;
   endfunction

   function automatic logic [6:0] div_const(input logic [1:0] k);
      logic [6:0] d;
      case (k)
         2'd0:    d = 7'd72;
         2'd1:    d = 7'd42;
         2'd2:    d = 7'd20;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

   // Round half up, then shift right arithmetic
   function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                        input int unsigned sh);
      logic signed [PROD_W-1:0] half;
      half = PROD_W'(1) << (sh - 1);
      return (v + half) >>> sh;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### src/cvm_mul.sv
// Shared signed multiplier with a registered product.
// Depends on cvm_pkg for the operand and product widths.
`timescale 1ns / 1ps

module cvm_mul
   import cvm_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  mul_a,
   input  logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

### src/cvm_core.sv
// Camera state and the sequencer that drives the shared multiplier for
// rotate, move and view rebuild. Depends on cvm_pkg and cvm_mul.
`timescale 1ns / 1ps

module cvm_core
   import cvm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  core_cmd_type  cmd,
   input  cfg_type       cfg,
   input  logic          out_free,
   output core_stat_type stat,
   output rsp_type       view
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_ROT_DY, ST_ROT_PIT, ST_ROT_WRAP,
      ST_MOV_SPD, ST_MOV_F, ST_MOV_DIR, ST_MOV_MUL, ST_MOV_ADD,
      ST_SIN_X, ST_SIN_XX, ST_SIN_DV0, ST_SIN_DV1, ST_SIN_DV2, ST_SIN_FIN,
      ST_UPD_PROD, ST_MAC, ST_ACC, ST_DONE
   } state_type;

   state_type state_ff;
   req_type   item_ff;

   logic signed [14:0]       pitch_ff;
   logic [15:0]              yaw_ff;
   logic signed [WRAP_W-1:0] wrap_ff;
   logic signed [31:0]       pos_ff [3];
   logic signed [15:0]       basis_ff [9];
   logic signed [31:0]       shift_ff [3];
   logic signed [15:0]       trig_ff [4];
   logic [24:0]              speed_ff;
   logic signed [15:0]       f_ff;
   logic signed [15:0]       r_ff;
   logic [1:0]               idx_ff;
   logic [1:0]               j_ff;
   logic [1:0]               k_ff;
   logic                     neg_ff;
   logic [30:0]              x_ff;
   logic [31:0]              x2_ff;
   logic [31:0]              v_ff;
   logic [31:0]              q0_ff;
   logic [2:0]               m_ff;
   logic [1:0]               row_ff;
   logic [1:0]               col_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod;

   logic [3:0]               basis_idx;
   logic signed [15:0]       basis_rd;
   logic [1:0]               pos_idx;
   logic signed [31:0]       pos_rd;

   logic signed [WRAP_W-1:0] ang_sel;
   logic signed [WRAP_W-1:0] ang_w;
   logic [15:0]              ang_fold;
   logic [1:0]               quad;
   logic [15:0]              quad_base;
   logic [13:0]              rem_q;
   logic [13:0]              rr;

   logic [31:0]              q0_val;
   logic [32:0]              rem_d;
   logic [31:0]              q_fix;
   logic [30:0]              t_val;
   logic [31:0]              s_hi;
   logic [16:0]              s_rnd;
   logic [16:0]              s_cap;
   logic signed [15:0]       trig_val;

   logic signed [16:0]       fr_sum;
   logic signed [16:0]       d_val;
   logic signed [WRAP_W-1:0] step_in;
   logic signed [WRAP_W-1:0] pitch_in;
   logic signed [15:0]       prd_in;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [31:0]       shift_in;
   logic signed [31:0]       pos_in;

   cvm_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   // Single read port into the basis and position registers
   always_comb begin
      unique case (state_ff)
         ST_MOV_F: basis_idx = 4'd6 + 4'(idx_ff);
         ST_MAC:   basis_idx = 4'(row_ff) * 4'd3 + 4'(col_ff);
         default:  basis_idx = 4'(idx_ff);
      endcase
      pos_idx  = (state_ff == ST_MAC) ? col_ff : idx_ff;
      basis_rd = basis_ff[basis_idx];
      pos_rd   = pos_ff[pos_idx];
   end

   // Fold the selected angle into the first quadrant
   always_comb begin
      case (j_ff)
         2'd0:    ang_sel = WRAP_W'(pitch_ff);
         2'd1:    ang_sel = WRAP_W'(pitch_ff) + WRAP_W'(QUARTER_TURN);
         2'd2:    ang_sel = WRAP_W'(signed'({1'b0, yaw_ff}));
         default: ang_sel = WRAP_W'(signed'({1'b0, yaw_ff})) + WRAP_W'(QUARTER_TURN);
      endcase
      if (ang_sel < 0) begin
         ang_w = ang_sel + WRAP_W'(FULL_TURN);
      end else if (ang_sel >= WRAP_W'(FULL_TURN)) begin
         ang_w = ang_sel - WRAP_W'(FULL_TURN);
      end else begin
         ang_w = ang_sel;
      end
      ang_fold = ang_w[15:0];
      if (ang_fold < 16'(QUARTER_TURN)) begin
         quad = 2'd0;
         quad_base = 16'd0;
      end else if (ang_fold < 16'(2 * QUARTER_TURN)) begin
         quad = 2'd1;
         quad_base = 16'(QUARTER_TURN);
      end else if (ang_fold < 16'(3 * QUARTER_TURN)) begin
         quad = 2'd2;
         quad_base = 16'(2 * QUARTER_TURN);
      end else begin
         quad = 2'd3;
         quad_base = 16'(3 * QUARTER_TURN);
      end
      rem_q = 14'(ang_fold - quad_base);
      rr    = quad[0] ? (14'(QUARTER_TURN) - rem_q) : rem_q;
   end

   // Divide-by-constant correction and sine rounding
   always_comb begin
      q0_val = 32'(prod >> div_shift(k_ff));
      rem_d  = 33'(v_ff) - prod[32:0];
      q_fix  = (rem_d >= 33'(div_const(k_ff))) ? (q0_ff + 32'd1) : q0_ff;
      t_val  = Q30_ONE - 31'(q_fix);
      s_hi   = prod[61:30];
      s_rnd  = 17'((33'(s_hi) + 33'd32768) >> 16);
      s_cap  = (s_rnd > SINE_CAP) ? SINE_CAP : s_rnd;
      trig_val = neg_ff ? -signed'(16'(s_cap)) : signed'(16'(s_cap));
   end

   // Direction, rounding and saturation helpers
   always_comb begin
      fr_sum = (item_ff.move_dir == DIR_STRAFE_RIGHT) ?
               (17'(f_ff) + 17'(basis_rd)) : (17'(f_ff) - 17'(basis_rd));
      case (item_ff.move_dir)
         DIR_FORWARD:      d_val = 17'(f_ff);
         DIR_BACKWARD:     d_val = -17'(f_ff);
         DIR_RIGHT:        d_val = 17'(r_ff);
         DIR_LEFT:         d_val = -17'(r_ff);
         DIR_STRAFE_RIGHT,
         DIR_STRAFE_LEFT:  d_val = 17'(rnd_shr(prod, 14));
         default:          d_val = 17'sd0;
      endcase
      step_in  = WRAP_W'(rnd_shr(prod, 13));
      pitch_in = WRAP_W'(pitch_ff) + step_in;
      prd_in   = 16'(rnd_shr(prod, 14));
      acc_in   = ((col_ff == 2'd0) ? ACC_W'(0) : acc_ff) + ACC_W'(prod);
      shift_in = sat32(-rnd_shr(PROD_W'(acc_in), 14));
      pos_in   = sat32(PROD_W'(pos_rd) + rnd_shr(prod, 14));
   end

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.item.func == FUNC_MOVE) begin
               mul_a = MUL_W'(cfg.speed);
               mul_b = MUL_W'(cmd.item.delta_time);
            end else begin
               mul_a = MUL_W'(cmd.item.mouse_dx);
               mul_b = MUL_W'(cfg.sens);
            end
         end
         ST_ROT_DY: begin
            mul_a = MUL_W'(item_ff.mouse_dy);
            mul_b = MUL_W'(cfg.sens);
         end
         ST_MOV_DIR: begin
            mul_a = MUL_W'(fr_sum);
            mul_b = MUL_W'(INV_SQRT2);
         end
         ST_MOV_MUL: begin
            mul_a = MUL_W'(d_val);
            mul_b = MUL_W'(speed_ff);
         end
         ST_SIN_X: begin
            mul_a = MUL_W'(rr);
            mul_b = MUL_W'(RAD_PER_UNIT);
         end
         ST_SIN_XX: begin
            mul_a = MUL_W'(prod[30:0]);
            mul_b = MUL_W'(prod[30:0]);
         end
         ST_SIN_DV0: begin
            mul_a = MUL_W'(prod[61:30]);
            mul_b = MUL_W'(div_recip(k_ff));
         end
         ST_SIN_DV1: begin
            mul_a = MUL_W'(q0_val);
            mul_b = MUL_W'(div_const(k_ff));
         end
         ST_SIN_DV2: begin
            mul_a = (k_ff == 2'd3) ? MUL_W'(x_ff) : MUL_W'(x2_ff);
            mul_b = MUL_W'(t_val);
         end
         ST_UPD_PROD: begin
            case (m_ff)
               3'd0: begin
                  mul_a = MUL_W'(trig_ff[0]);
                  mul_b = MUL_W'(trig_ff[2]);
               end
               3'd1: begin
                  mul_a = MUL_W'(trig_ff[0]);
                  mul_b = MUL_W'(trig_ff[3]);
               end
               3'd2: begin
                  mul_a = MUL_W'(trig_ff[1]);
                  mul_b = MUL_W'(trig_ff[2]);
               end
               3'd3: begin
                  mul_a = MUL_W'(trig_ff[1]);
                  mul_b = MUL_W'(trig_ff[3]);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         ST_MAC: begin
            mul_a = MUL_W'(basis_rd);
            mul_b = MUL_W'(pos_rd);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer and camera state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pitch_ff <= '0;
         yaw_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]   <= '0;
            shift_ff[i] <= '0;
         end
         for (int i = 0; i < 9; i++) begin
            basis_ff[i] <= (i % 4 == 0) ? UNIT_Q14 : 16'sd0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.start) begin
                  item_ff <= cmd.item;
                  idx_ff  <= 2'd0;
                  j_ff    <= 2'd0;
                  case (cmd.item.func)
                     FUNC_ROTATE: state_ff <= ST_ROT_DY;
                     FUNC_MOVE:   state_ff <= ST_MOV_SPD;
                     FUNC_UPDATE: state_ff <= ST_SIN_X;
                     default:     state_ff <= ST_DONE;
                  endcase
               end
            end
            // Rotate: add yaw step, clamp pitch, wrap yaw
            ST_ROT_DY: begin
               wrap_ff  <= WRAP_W'(signed'({1'b0, yaw_ff})) + step_in;
               state_ff <= ST_ROT_PIT;
            end
            ST_ROT_PIT: begin
               if (pitch_in > WRAP_W'(PITCH_LIMIT)) begin
                  pitch_ff <= 15'(PITCH_LIMIT);
               end else if (pitch_in < -WRAP_W'(PITCH_LIMIT)) begin
                  pitch_ff <= -15'(PITCH_LIMIT);
               end else begin
                  pitch_ff <= 15'(pitch_in);
               end
               state_ff <= ST_ROT_WRAP;
            end
            ST_ROT_WRAP: begin
               if (wrap_ff < 0) begin
                  wrap_ff <= wrap_ff + WRAP_W'(FULL_TURN);
               end else if (wrap_ff >= WRAP_W'(FULL_TURN)) begin
                  wrap_ff <= wrap_ff - WRAP_W'(FULL_TURN);
               end else begin
                  yaw_ff   <= wrap_ff[15:0];
                  state_ff <= ST_DONE;
               end
            end
            // Move: speed, then one axis at a time
            ST_MOV_SPD: begin
               speed_ff <= 25'(rnd_shr(prod, 8));
               state_ff <= ST_MOV_F;
            end
            ST_MOV_F: begin
               f_ff     <= basis_rd;
               state_ff <= ST_MOV_DIR;
            end
            ST_MOV_DIR: begin
               r_ff     <= basis_rd;
               state_ff <= ST_MOV_MUL;
            end
            ST_MOV_MUL: begin
               state_ff <= ST_MOV_ADD;
            end
            ST_MOV_ADD: begin
               pos_ff[idx_ff] <= pos_in;
               if (idx_ff == 2'd2) begin
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= ST_MOV_F;
               end
            end
            // Sine: x, x squared, four Horner steps, round
            ST_SIN_X: begin
               neg_ff   <= quad[1];
               k_ff     <= 2'd0;
               state_ff <= ST_SIN_XX;
            end
            ST_SIN_XX: begin
               x_ff     <= prod[30:0];
               state_ff <= ST_SIN_DV0;
            end
            ST_SIN_DV0: begin
               v_ff <= prod[61:30];
               if (k_ff == 2'd0) begin
                  x2_ff <= prod[61:30];
               end
               state_ff <= ST_SIN_DV1;
            end
            ST_SIN_DV1: begin
               q0_ff    <= q0_val;
               state_ff <= ST_SIN_DV2;
            end
            ST_SIN_DV2: begin
               if (k_ff == 2'd3) begin
                  state_ff <= ST_SIN_FIN;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= ST_SIN_DV0;
               end
            end
            ST_SIN_FIN: begin
               trig_ff[j_ff] <= trig_val;
               if (j_ff == 2'd3) begin
                  m_ff     <= 3'd0;
                  state_ff <= ST_UPD_PROD;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_SIN_X;
               end
            end
            // Rebuild the rotation rows
            ST_UPD_PROD: begin
               case (m_ff)
                  3'd0: begin
                     basis_ff[0] <= trig_ff[3];
                     basis_ff[1] <= 16'sd0;
                     basis_ff[2] <= trig_ff[2];
                     basis_ff[4] <= trig_ff[1];
                     basis_ff[7] <= trig_ff[0];
                  end
                  3'd1:    basis_ff[3] <= prd_in;
                  3'd2:    basis_ff[5] <= -prd_in;
                  3'd3:    basis_ff[6] <= -prd_in;
                  default: basis_ff[8] <= prd_in;
               endcase
               if (m_ff == 3'd4) begin
                  row_ff   <= 2'd0;
                  col_ff   <= 2'd0;
                  state_ff <= ST_MAC;
               end else begin
                  m_ff <= m_ff + 3'd1;
               end
            end
            // Translation: multiply-accumulate row by position
            ST_MAC: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff <= acc_in;
               if (col_ff == 2'd2) begin
                  shift_ff[row_ff] <= shift_in;
                  col_ff <= 2'd0;
                  if (row_ff == 2'd2) begin
                     state_ff <= ST_DONE;
                  end else begin
                     row_ff   <= row_ff + 2'd1;
                     state_ff <= ST_MAC;
                  end
               end else begin
                  col_ff   <= col_ff + 2'd1;
                  state_ff <= ST_MAC;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = (state_ff == ST_DONE);

   assign view.right_x = basis_ff[0];
   assign view.right_y = basis_ff[1];
   assign view.right_z = basis_ff[2];
   assign view.up_x    = basis_ff[3];
   assign view.up_y    = basis_ff[4];
   assign view.up_z    = basis_ff[5];
   assign view.front_x = basis_ff[6];
   assign view.front_y = basis_ff[7];
   assign view.front_z = basis_ff[8];
   assign view.shift_x = shift_ff[0];
   assign view.shift_y = shift_ff[1];
   assign view.shift_z = shift_ff[2];

`ifndef ASSERT_OFF
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      (pitch_ff <= PITCH_LIMIT) && (pitch_ff >= -PITCH_LIMIT))
      else $error("pitch outside clamp limits");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      yaw_ff < 16'(FULL_TURN))
      else $error("yaw not wrapped into one turn");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && cmd.start |=> (state_ff != ST_IDLE))
      else $error("sequencer ignored a start");

   a_done_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_free |=> (state_ff == ST_IDLE))
      else $error("sequencer held after result handoff");
`endif

endmodule

### src/camera_view_matrix_update.sv
// Rotate, move and view update each step through their own sequencer states before rsp_valid;
// the yaw wrap removes one full turn per pass, and an unused code goes straight to done.
// One item at a time: req_ready is high only while the sequencer is idle, so the next
// beat is taken in the cycle after a result loads; all products share one 34x34 multiplier.
// A finished result waits in the output register while the next item is accepted.
// Synchronous active-high reset: identity basis, zero angles, position and shift.
`timescale 1ns / 1ps

module camera_view_matrix_update
   import cvm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type       cfg_ff;
   core_cmd_type  cmd;
   core_stat_type stat;
   rsp_type       view;
   logic          out_free;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = stat.idle;
   assign cmd.start    = req_valid && stat.idle;
   assign cmd.item     = req_data;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   cvm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .stat     (stat),
      .view     (view)
   );

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed <= SPEED_RESET;
         cfg_ff.sens  <= SENS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED: cfg_ff.speed <= csr_wdata;
            CSR_SENS:  cfg_ff.sens  <= csr_wdata;
            default:   cfg_ff.speed <= cfg_ff.speed;
         endcase
      end
   end

   // Result register: load a finished view, hold until the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done && out_free) begin
         rsp_data_ff <= view;
      end
   end

endmodule

### verif/tb_camera_view_matrix_update.sv
// Self-checking bench for camera_view_matrix_update: random and directed camera beats
// checked against a cycle-free model of yaw, pitch, movement and the view rebuild.
// Depends on cvm_pkg for payload types, operation codes and register indexes.
`timescale 1ns / 1ps

module tb_camera_view_matrix_update;
   import cvm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_index;
   logic [15:0] csr_wdata;

   camera_view_matrix_update DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Camera state mirrored by the bench
   longint speed_reg, sens_reg;
   longint cam_pos[3];
   longint pitch_q7, yaw_q7;
   longint basis[9];
   longint shift_vec[3];

   req_type pending_beats[$];
   rsp_type view_queue[$];
   int      error_count;
   int      stall_pct;
   bit      stim_done;
   int      quiet_cycles;

   // Round half up by 2^sh
   function automatic longint round_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Taylor sine over the first quadrant, Q2.14
   function automatic longint quad_sine(longint r);
      longint unsigned x, x2, t, s;
      x  = longint'(r) * 146409;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824 - x2 / 72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      s  = (s + 32768) >> 16;
      if (s > 16384) s = 16384;
      return longint'(s);
   endfunction

   function automatic longint deg_sine(longint a);
      longint q, r, v;
      a = a % FULL_TURN;
      if (a < 0) a += FULL_TURN;
      q = a / QUARTER_TURN;
      r = a % QUARTER_TURN;
      v = q[0] ? quad_sine(QUARTER_TURN - r) : quad_sine(r);
      return (q >= 2) ? -v : v;
   endfunction

   // Advance the camera by one beat and return the stored view
   function automatic rsp_type camera_step(req_type b);
      longint dyaw, dpit, y, p, spd, f, r, sp, cp, sy, cy, acc;
      longint d[3];
      rsp_type v;
      case (b.func)
         FUNC_UPDATE: begin
            sp = deg_sine(pitch_q7);
            cp = deg_sine(pitch_q7 + QUARTER_TURN);
            sy = deg_sine(yaw_q7);
            cy = deg_sine(yaw_q7 + QUARTER_TURN);
            basis[0] = cy; basis[1] = 0; basis[2] = sy;
            basis[3] = round_shift(sp * sy, 14);
            basis[4] = cp;
            basis[5] = -round_shift(sp * cy, 14);
            basis[6] = -round_shift(cp * sy, 14);
            basis[7] = sp;
            basis[8] = round_shift(cp * cy, 14);
            for (int i = 0; i < 3; i++) begin
               acc = basis[3*i] * cam_pos[0] + basis[3*i+1] * cam_pos[1]
                   + basis[3*i+2] * cam_pos[2];
               shift_vec[i] = clamp32(-round_shift(acc, 14));
            end
         end
         FUNC_MOVE: begin
            spd = round_shift(speed_reg * longint'(b.delta_time), 8);
            for (int i = 0; i < 3; i++) begin
               f = basis[6+i];
               r = basis[i];
               case (b.move_dir)
                  DIR_FORWARD:      d[i] = f;
                  DIR_BACKWARD:     d[i] = -f;
                  DIR_RIGHT:        d[i] = r;
                  DIR_LEFT:         d[i] = -r;
                  DIR_STRAFE_RIGHT: d[i] = round_shift((f + r) * 11585, 14);
                  DIR_STRAFE_LEFT:  d[i] = round_shift((f - r) * 11585, 14);
                  default:          d[i] = 0;
               endcase
            end
            for (int i = 0; i < 3; i++)
               cam_pos[i] = clamp32(cam_pos[i] + round_shift(d[i] * spd, 14));
         end
         FUNC_ROTATE: begin
            dyaw = round_shift(longint'(b.mouse_dx) * sens_reg, 13);
            dpit = round_shift(longint'(b.mouse_dy) * sens_reg, 13);
            y = (yaw_q7 + dyaw) % FULL_TURN;
            if (y < 0) y += FULL_TURN;
            yaw_q7 = y;
            p = pitch_q7 + dpit;
            if (p > PITCH_LIMIT) p = PITCH_LIMIT;
            if (p < -PITCH_LIMIT) p = -PITCH_LIMIT;
            pitch_q7 = p;
         end
         default: ;
      endcase
      v.right_x = 16'(basis[0]); v.right_y = 16'(basis[1]); v.right_z = 16'(basis[2]);
      v.up_x    = 16'(basis[3]); v.up_y    = 16'(basis[4]); v.up_z    = 16'(basis[5]);
      v.front_x = 16'(basis[6]); v.front_y = 16'(basis[7]); v.front_z = 16'(basis[8]);
      v.shift_x = 32'(shift_vec[0]);
      v.shift_y = 32'(shift_vec[1]);
      v.shift_z = 32'(shift_vec[2]);
      return v;
   endfunction

   function automatic req_type random_beat();
      req_type b;
      int pick;
      b.func       = $urandom_range(0, 99) < 3 ? 2'd3 : 2'($urandom_range(0, 2));
      b.move_dir   = $urandom_range(0, 99) < 6 ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
      b.delta_time = 16'($urandom);
      pick = $urandom_range(0, 9);
      b.mouse_dx   = pick < 7 ? 16'($signed($urandom_range(0, 4000)) - 2000) : 16'($urandom);
      pick = $urandom_range(0, 9);
      b.mouse_dy   = pick < 7 ? 16'($signed($urandom_range(0, 4000)) - 2000) : 16'($urandom);
      return b;
   endfunction

   function automatic req_type make_beat(logic [1:0] fn, logic [2:0] dir, logic [15:0] dt,
                                         logic [15:0] dx, logic [15:0] dy);
      req_type b;
      b.func = fn; b.move_dir = dir; b.delta_time = dt; b.mouse_dx = dx; b.mouse_dy = dy;
      return b;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drive request beats from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || req_ready) begin
         if (pending_beats.size() > 0 && $urandom_range(0, 99) >= stall_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_beats.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict on accept, check each result beat
   always @(posedge clock) begin
      rsp_type exp_view;
      bit      beat_seen;
      if (reset) begin
         rsp_ready    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         beat_seen = (req_valid && req_ready) || (csr_valid && csr_ready)
                     || (rsp_valid && rsp_ready);
         quiet_cycles <= beat_seen ? 0 : quiet_cycles + 1;
         if (req_valid && req_ready) begin
            view_queue.push_back(camera_step(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (view_queue.size() == 0) begin
               $error("result beat with no expectation");
               error_count++;
            end else begin
               exp_view = view_queue.pop_front();
               if (rsp_data.right_x !== exp_view.right_x) begin
                  $error("right_x exp %0d got %0d", exp_view.right_x, rsp_data.right_x);
                  error_count++;
               end
               if (rsp_data.right_y !== exp_view.right_y) begin
                  $error("right_y exp %0d got %0d", exp_view.right_y, rsp_data.right_y);
                  error_count++;
               end
               if (rsp_data.right_z !== exp_view.right_z) begin
                  $error("right_z exp %0d got %0d", exp_view.right_z, rsp_data.right_z);
                  error_count++;
               end
               if (rsp_data.up_x !== exp_view.up_x) begin
                  $error("up_x exp %0d got %0d", exp_view.up_x, rsp_data.up_x);
                  error_count++;
               end
               if (rsp_data.up_y !== exp_view.up_y) begin
                  $error("up_y exp %0d got %0d", exp_view.up_y, rsp_data.up_y);
                  error_count++;
               end
               if (rsp_data.up_z !== exp_view.up_z) begin
                  $error("up_z exp %0d got %0d", exp_view.up_z, rsp_data.up_z);
                  error_count++;
               end
               if (rsp_data.front_x !== exp_view.front_x) begin
                  $error("front_x exp %0d got %0d", exp_view.front_x, rsp_data.front_x);
                  error_count++;
               end
               if (rsp_data.front_y !== exp_view.front_y) begin
                  $error("front_y exp %0d got %0d", exp_view.front_y, rsp_data.front_y);
                  error_count++;
               end
               if (rsp_data.front_z !== exp_view.front_z) begin
                  $error("front_z exp %0d got %0d", exp_view.front_z, rsp_data.front_z);
                  error_count++;
               end
               if (rsp_data.shift_x !== exp_view.shift_x) begin
                  $error("shift_x exp %0d got %0d", exp_view.shift_x, rsp_data.shift_x);
                  error_count++;
               end
               if (rsp_data.shift_y !== exp_view.shift_y) begin
                  $error("shift_y exp %0d got %0d", exp_view.shift_y, rsp_data.shift_y);
                  error_count++;
               end
               if (rsp_data.shift_z !== exp_view.shift_z) begin
                  $error("shift_z exp %0d got %0d", exp_view.shift_z, rsp_data.shift_z);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (!reset && quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Wait until the queues drain and the block is idle
   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || view_queue.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Write one register while the block is idle
   task automatic write_csr(logic idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SPEED) speed_reg = longint'(val);
      else sens_reg = longint'(val);
      @(posedge clock);
   endtask

   task automatic load_random(int n);
      for (int i = 0; i < n; i++) pending_beats.push_back(random_beat());
   endtask

   initial begin
      logic [15:0] speed_set[4];
      logic [15:0] sens_set[4];
      error_count = 0;
      stim_done   = 1'b0;
      stall_pct   = 18;
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_SPEED;
      csr_wdata = '0;
      speed_reg = SPEED_RESET;
      sens_reg  = SENS_RESET;
      pitch_q7  = 0;
      yaw_q7    = 0;
      for (int i = 0; i < 3; i++) begin
         cam_pos[i] = 0;
         shift_vec[i] = 0;
      end
      for (int i = 0; i < 9; i++) basis[i] = (i % 4 == 0) ? 16384 : 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation, field extremes, pitch clamp, yaw wrap, bad codes
      pending_beats.push_back(make_beat(FUNC_UPDATE, DIR_FORWARD, 16'h0000, 16'h0000, 16'h0000));
      for (int d = 0; d < 8; d++)
         pending_beats.push_back(make_beat(FUNC_MOVE, 3'(d), 16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_beats.push_back(make_beat(FUNC_MOVE, DIR_FORWARD, 16'h0000, 16'h7FFF, 16'h8000));
      pending_beats.push_back(make_beat(FUNC_ROTATE, DIR_FORWARD, 16'h0000, 16'h7FFF, 16'h7FFF));
      pending_beats.push_back(make_beat(FUNC_UPDATE, DIR_FORWARD, 16'h0000, 16'h0000, 16'h0000));
      pending_beats.push_back(make_beat(FUNC_ROTATE, DIR_FORWARD, 16'h0000, 16'h8000, 16'h8000));
      pending_beats.push_back(make_beat(FUNC_ROTATE, DIR_FORWARD, 16'h0000, 16'hFFFF, 16'h0001));
      pending_beats.push_back(make_beat(FUNC_UPDATE, DIR_FORWARD, 16'h0000, 16'h0000, 16'h0000));
      pending_beats.push_back(make_beat(2'd3, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      for (int d = 0; d < 6; d++)
         pending_beats.push_back(make_beat(FUNC_MOVE, 3'(d), 16'h8000, 16'h0000, 16'h0000));
      pending_beats.push_back(make_beat(FUNC_UPDATE, DIR_FORWARD, 16'h0000, 16'h0000, 16'h0000));
      drain();

      // Random phases across register settings, extremes included
      speed_set = '{16'hFFFF, 16'h0000, 16'h0100, 16'd640};
      sens_set  = '{16'hFFFF, 16'h0000, 16'h0800, 16'd6554};
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_SPEED, speed_set[ph]);
         write_csr(CSR_SENS, sens_set[ph]);
         stall_pct = (ph == 2) ? 0 : 18;
         load_random(330);
         drain();
      end
      // Saturate position with fast long moves, then rebuild
      write_csr(CSR_SPEED, 16'hFFFF);
      for (int i = 0; i < 40; i++)
         pending_beats.push_back(make_beat(FUNC_MOVE, 3'($urandom_range(0, 5)), 16'hFFFF,
                                           16'h0000, 16'h0000));
      pending_beats.push_back(make_beat(FUNC_UPDATE, DIR_FORWARD, 16'h0000, 16'h0000, 16'h0000));
      drain();
      stim_done = 1'b1;

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
